@@ hdl/shamh_pkg.sv @@
`timescale 1ns / 1ps

package shamh_pkg;

    // Input word: one message byte plus framing
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } shamh_in_t;

    // Output word: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } shamh_out_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } shamh_state_t;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_val;
        logic       shift_word;
        logic       wv_load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       chain_update;
        logic       chain_init;
        logic [2:0] out_idx;
    } shamh_ctrl_t;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [5:0] LAST_POS     = 6'd63;
    localparam logic [5:0] LAST_ROUND   = 6'd63;
    localparam logic [2:0] LAST_WORD    = 3'd7;

    function automatic logic [31:0] init_chain(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ hdl/shamh_sched.sv @@
`timescale 1ns / 1ps

// 16-word block buffer / message schedule window.
// Byte load shifts the whole 512-bit block left by one byte (big-endian pack);
// a round shifts it by one word and appends the next schedule word.
module shamh_sched (
    input  logic                aclk,
    input  shamh_pkg::shamh_ctrl_t ctl,
    output logic [31:0]         w_cur
);

    logic [31:0] win_reg [16];
    logic [31:0] w_new;

    // next schedule word, W[t+16]
    assign w_new = shamh_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                 + shamh_pkg::small_sigma0(win_reg[1]) + win_reg[0];

    assign w_cur = win_reg[0];

    always_ff @(posedge aclk) begin
        if (ctl.load_byte) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], ctl.byte_val};
        end else if (ctl.shift_word) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
        end
    end

endmodule

@@ hdl/shamh_round.sv @@
`timescale 1ns / 1ps

// Working variables a..h, the shared round unit and the chaining state.
module shamh_round (
    input  logic                aclk,
    input  logic                aresetn,
    input  shamh_pkg::shamh_ctrl_t ctl,
    input  logic [31:0]         w_cur,
    output logic [31:0]         chain_word
);

    logic [31:0] wv_reg    [8];
    logic [31:0] chain_reg [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // one compression round
    always_comb begin
        ch  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t1  = wv_reg[7] + shamh_pkg::big_sigma1(wv_reg[4]) + ch
            + shamh_pkg::round_k(ctl.round_idx) + w_cur;
        t2  = shamh_pkg::big_sigma0(wv_reg[0]) + maj;
    end

    // working variables
    always_ff @(posedge aclk) begin
        if (ctl.wv_load) begin
            for (int i = 0; i < 8; i++) begin
                wv_reg[i] <= chain_reg[i];
            end
        end else if (ctl.round_en) begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    // chaining state: init on reset / after digest, accumulate after each block
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.chain_init) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= shamh_pkg::init_chain(3'(i));
            end
        end else if (ctl.chain_update) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= chain_reg[i] + wv_reg[i];
            end
        end
    end

    assign chain_word = chain_reg[ctl.out_idx];

endmodule

@@ hdl/shamh_ctrl.sv @@
`timescale 1ns / 1ps

// Sequencer: byte intake, padding, round count, digest readout.
module shamh_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  shamh_pkg::shamh_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output shamh_pkg::shamh_ctrl_t ctl
);

    shamh_pkg::shamh_state_t state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_reg, out_next;
    logic        ending_reg, ending_next;
    logic        sent80_reg, sent80_next;
    logic        lenph_reg, lenph_next;
    logic [7:0]  len_byte;

    // length byte for the current slot (56 -> most significant)
    always_comb begin
        case (pos_reg[2:0])
            3'd0:    len_byte = bitlen_reg[63:56];
            3'd1:    len_byte = bitlen_reg[55:48];
            3'd2:    len_byte = bitlen_reg[47:40];
            3'd3:    len_byte = bitlen_reg[39:32];
            3'd4:    len_byte = bitlen_reg[31:24];
            3'd5:    len_byte = bitlen_reg[23:16];
            3'd6:    len_byte = bitlen_reg[15:8];
            default: len_byte = bitlen_reg[7:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= shamh_pkg::ST_IDLE;
            pos_reg    <= '0;
            bitlen_reg <= '0;
            round_reg  <= '0;
            out_reg    <= '0;
            ending_reg <= 1'b0;
            sent80_reg <= 1'b0;
            lenph_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            bitlen_reg <= bitlen_next;
            round_reg  <= round_next;
            out_reg    <= out_next;
            ending_reg <= ending_next;
            sent80_reg <= sent80_next;
            lenph_reg  <= lenph_next;
        end
    end

    // next state and datapath controls
    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        bitlen_next = bitlen_reg;
        round_next  = round_reg;
        out_next    = out_reg;
        ending_next = ending_reg;
        sent80_next = sent80_reg;
        lenph_next  = lenph_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        ctl              = '0;
        ctl.round_idx    = round_reg;
        ctl.out_idx      = out_reg;

        unique case (state_reg)
            shamh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ending_next = s_data.end_of_message;
                    if (s_data.end_of_message) begin
                        state_next = shamh_pkg::ST_PAD;
                    end
                    if (s_data.byte_present) begin
                        ctl.load_byte = 1'b1;
                        ctl.byte_val  = s_data.data_byte;
                        pos_next      = pos_reg + 6'd1;
                        bitlen_next   = bitlen_reg + 64'd8;
                        if (pos_reg == shamh_pkg::LAST_POS) begin
                            ctl.wv_load = 1'b1;
                            round_next  = '0;
                            state_next  = shamh_pkg::ST_ROUND;
                        end
                    end
                end
            end

            shamh_pkg::ST_ROUND: begin
                ctl.round_en   = 1'b1;
                ctl.shift_word = 1'b1;
                round_next     = round_reg + 6'd1;
                if (round_reg == shamh_pkg::LAST_ROUND) begin
                    state_next = shamh_pkg::ST_UPDATE;
                end
            end

            shamh_pkg::ST_UPDATE: begin
                ctl.chain_update = 1'b1;
                out_next         = '0;
                if (lenph_reg) begin
                    state_next = shamh_pkg::ST_OUT;
                end else if (ending_reg) begin
                    state_next = shamh_pkg::ST_PAD;
                end else begin
                    state_next = shamh_pkg::ST_IDLE;
                end
            end

            shamh_pkg::ST_PAD: begin
                ctl.load_byte = 1'b1;
                pos_next      = pos_reg + 6'd1;
                if (!sent80_reg) begin
                    ctl.byte_val = shamh_pkg::PAD_MARK;
                    sent80_next  = 1'b1;
                end else if (lenph_reg || pos_reg == shamh_pkg::LEN_POS) begin
                    ctl.byte_val = len_byte;
                    lenph_next   = 1'b1;
                end else begin
                    ctl.byte_val = 8'h00;
                end
                if (pos_reg == shamh_pkg::LAST_POS) begin
                    ctl.wv_load = 1'b1;
                    round_next  = '0;
                    state_next  = shamh_pkg::ST_ROUND;
                end
            end

            shamh_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    out_next = out_reg + 3'd1;
                    if (out_reg == shamh_pkg::LAST_WORD) begin
                        ctl.chain_init = 1'b1;
                        pos_next       = '0;
                        bitlen_next    = '0;
                        round_next     = '0;
                        ending_next    = 1'b0;
                        sent80_next    = 1'b0;
                        lenph_next     = 1'b0;
                        state_next     = shamh_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = shamh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/sha256_message_hasher.sv @@
`timescale 1ns / 1ps

// SHA-256 hasher taking one message byte per input word and returning the
// digest as eight 32-bit words, most significant first. Every 64th byte
// starts a compression of 64 rounds at one round per cycle through a single
// shared round unit, after which the result is folded into the chaining
// state; s_ready is low throughout. The end-of-message word triggers padding,
// fed one byte per cycle except while a compression runs, one or two more
// compressions, then the eight digest words on the m_ channel; s_ready
// stays low until the last digest word is taken. A word with end_of_message
// and no byte closes the message before it (alone, it hashes the empty
// message). Bit length wraps at 2^64.
module sha256_message_hasher (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  shamh_pkg::shamh_in_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output shamh_pkg::shamh_out_t m_data
);

    shamh_pkg::shamh_ctrl_t ctl;
    logic [31:0]            w_cur;
    logic [31:0]            chain_word;

    shamh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    shamh_sched u_sched (
        .aclk  (aclk),
        .ctl   (ctl),
        .w_cur (w_cur)
    );

    shamh_round u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .w_cur      (w_cur),
        .chain_word (chain_word)
    );

    // digest word readout
    always_comb begin
        m_data.digest_word = chain_word;
        m_data.word_number = ctl.out_idx;
        m_data.last_word   = (ctl.out_idx == shamh_pkg::LAST_WORD);
    end

endmodule

@@ hdl/shamh_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks for the hasher.
module shamh_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input shamh_pkg::shamh_out_t m_data
);

    logic m_fire;
    assign m_fire = m_valid && m_ready;

    // intake and digest readout never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("s_ready high while digest word pending");

    // stalled digest word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("digest word changed while stalled");

    // words count up with no gaps inside a digest
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && !m_data.last_word |=>
            m_valid && m_data.word_number == 3'($past(m_data.word_number) + 3'd1))
        else $error("digest word sequence broken");

    // after the last word the block takes input again
    a_resume: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && m_data.last_word |=> s_ready && !m_valid)
        else $error("not ready after digest");

    // last flag sits only on word seven
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_word == (m_data.word_number == 3'd7)))
        else $error("last_word flag misplaced");

endmodule

bind sha256_message_hasher shamh_checker u_shamh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
